### src/scroll_address_register_unit_core_assert.svh
// Assertion macros for the scroll and address register unit.
// Used by the port checker; no other dependencies.
`ifndef SCROLL_ADDRESS_REGISTER_UNIT_CORE_ASSERT_SVH
`define SCROLL_ADDRESS_REGISTER_UNIT_CORE_ASSERT_SVH

// Checked only out of reset
`define SARU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define SARU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/saru_pkg.sv
// Shared types and constants for the scroll and address register unit.
// No dependencies.
package saru_pkg;

  // Event kinds
  localparam logic [3:0] KIND_CTRL_WR   = 4'd0;
  localparam logic [3:0] KIND_MASK_WR   = 4'd1;
  localparam logic [3:0] KIND_SCROLL_WR = 4'd2;
  localparam logic [3:0] KIND_ADDR_WR   = 4'd3;
  localparam logic [3:0] KIND_DATA      = 4'd4;
  localparam logic [3:0] KIND_STATUS_RD = 4'd5;
  localparam logic [3:0] KIND_INC_X     = 4'd6;
  localparam logic [3:0] KIND_INC_Y     = 4'd7;
  localparam logic [3:0] KIND_COPY_X    = 4'd8;
  localparam logic [3:0] KIND_COPY_Y    = 4'd9;

  // Coarse Y, coarse X and fine Y values that wrap
  localparam logic [4:0] COARSE_Y_LAST_ROW = 5'd29;
  localparam logic [4:0] COARSE_Y_MAX      = 5'd31;
  localparam logic [4:0] COARSE_X_MAX      = 5'd31;
  localparam logic [2:0] FINE_Y_MAX        = 3'd7;

  // Data port steps
  localparam logic [14:0] STEP_COLUMN = 15'd1;
  localparam logic [14:0] STEP_ROW    = 15'd32;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [14:0] vram_address;
    logic [13:0] name_fetch_address;
    logic [13:0] attr_fetch_address;
    logic [2:0]  attr_shift;
    logic [2:0]  fine_x;
    logic [2:0]  fine_y;
    logic        toggle;
  } result_t;

  // Handshake between the stages
  typedef struct packed {
    logic fire;
    logic out_ready;
  } stage_ctl_t;

endpackage

### src/saru_in_stage.sv
// Input register of the scroll and address register unit.
// Depends on saru_pkg.
module saru_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [3:0]           in_kind,
  input  logic [7:0]           in_data,
  input  saru_pkg::stage_ctl_t ctl_i,
  output logic                 full_o,
  output saru_pkg::item_t      item_o
);

  logic            valid_r;
  logic            valid_nxt;
  saru_pkg::item_t item_r;
  logic            accept;

  // Hold while the word cannot move on to the update stage
  assign in_stall = valid_r && !ctl_i.out_ready;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (ctl_i.fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.kind <= in_kind;
      item_r.data <= in_data;
    end
  end

  assign full_o = valid_r;
  assign item_o = item_r;

endmodule

### src/saru_exec.sv
// Scroll/address state registers and their combinational next-state update.
// Depends on saru_pkg.
module saru_exec (
  input  logic                 clk,
  input  logic                 rst_n,
  input  saru_pkg::stage_ctl_t ctl_i,
  input  saru_pkg::item_t      item_i,
  output saru_pkg::result_t    result_o
);

  logic [14:0] cur_r, cur_nxt;
  logic [14:0] tmp_r, tmp_nxt;
  logic [2:0]  fine_x_r, fine_x_nxt;
  logic        toggle_r, toggle_nxt;
  logic        row_step_r, row_step_nxt;
  logic        render_r, render_nxt;

  // Coarse X increment with horizontal nametable flip
  function automatic logic [14:0] bump_x(input logic [14:0] v);
    logic [14:0] r;
    r = v;
    if (v[4:0] == saru_pkg::COARSE_X_MAX) begin
      r[4:0] = 5'd0;
      r[10]  = ~v[10];
    end else begin
      r[4:0] = v[4:0] + 5'd1;
    end
    return r;
  endfunction

  // Fine/coarse Y increment; row 29 flips the vertical nametable
  function automatic logic [14:0] bump_y(input logic [14:0] v);
    logic [14:0] r;
    r = v;
    if (v[14:12] != saru_pkg::FINE_Y_MAX) begin
      r[14:12] = v[14:12] + 3'd1;
    end else begin
      r[14:12] = 3'd0;
      if (v[9:5] == saru_pkg::COARSE_Y_LAST_ROW) begin
        r[9:5] = 5'd0;
        r[11]  = ~v[11];
      end else if (v[9:5] == saru_pkg::COARSE_Y_MAX) begin
        r[9:5] = 5'd0;
      end else begin
        r[9:5] = v[9:5] + 5'd1;
      end
    end
    return r;
  endfunction

  // Next state per event kind
  always_comb begin
    cur_nxt      = cur_r;
    tmp_nxt      = tmp_r;
    fine_x_nxt   = fine_x_r;
    toggle_nxt   = toggle_r;
    row_step_nxt = row_step_r;
    render_nxt   = render_r;
    unique case (item_i.kind)
      saru_pkg::KIND_CTRL_WR: begin
        row_step_nxt    = item_i.data[2];
        tmp_nxt[11:10]  = item_i.data[1:0];
      end
      saru_pkg::KIND_MASK_WR: begin
        render_nxt = item_i.data[3] | item_i.data[4];
      end
      saru_pkg::KIND_SCROLL_WR: begin
        if (!toggle_r) begin
          tmp_nxt[4:0] = item_i.data[7:3];
          fine_x_nxt   = item_i.data[2:0];
        end else begin
          tmp_nxt[9:5]   = item_i.data[7:3];
          tmp_nxt[14:12] = item_i.data[2:0];
        end
        toggle_nxt = ~toggle_r;
      end
      saru_pkg::KIND_ADDR_WR: begin
        if (!toggle_r) begin
          tmp_nxt[13:8] = item_i.data[5:0];
          tmp_nxt[14]   = 1'b0;
        end else begin
          tmp_nxt[7:0] = item_i.data;
          cur_nxt      = {tmp_r[14:8], item_i.data};
        end
        toggle_nxt = ~toggle_r;
      end
      saru_pkg::KIND_DATA: begin
        cur_nxt = cur_r + (row_step_r ? saru_pkg::STEP_ROW : saru_pkg::STEP_COLUMN);
      end
      saru_pkg::KIND_STATUS_RD: begin
        toggle_nxt = 1'b0;
      end
      saru_pkg::KIND_INC_X: begin
        if (render_r) cur_nxt = bump_x(cur_r);
      end
      saru_pkg::KIND_INC_Y: begin
        if (render_r) cur_nxt = bump_y(cur_r);
      end
      saru_pkg::KIND_COPY_X: begin
        if (render_r) begin
          cur_nxt[4:0] = tmp_r[4:0];
          cur_nxt[10]  = tmp_r[10];
        end
      end
      saru_pkg::KIND_COPY_Y: begin
        if (render_r) begin
          cur_nxt[9:5]   = tmp_r[9:5];
          cur_nxt[11]    = tmp_r[11];
          cur_nxt[14:12] = tmp_r[14:12];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r      <= 15'd0;
      tmp_r      <= 15'd0;
      fine_x_r   <= 3'd0;
      toggle_r   <= 1'b0;
      row_step_r <= 1'b0;
      render_r   <= 1'b0;
    end else if (ctl_i.fire) begin
      cur_r      <= cur_nxt;
      tmp_r      <= tmp_nxt;
      fine_x_r   <= fine_x_nxt;
      toggle_r   <= toggle_nxt;
      row_step_r <= row_step_nxt;
      render_r   <= render_nxt;
    end
  end

  // Fetch addresses derived from the updated current address
  always_comb begin
    result_o.vram_address       = cur_nxt;
    result_o.name_fetch_address = {2'b10, cur_nxt[11:0]};
    result_o.attr_fetch_address = {2'b10, cur_nxt[11:10], 4'b1111, cur_nxt[9:7], cur_nxt[4:2]};
    result_o.attr_shift         = {cur_nxt[6], cur_nxt[1], 1'b0};
    result_o.fine_x             = fine_x_nxt;
    result_o.fine_y             = cur_nxt[14:12];
    result_o.toggle             = toggle_nxt;
  end

endmodule

### src/saru_out_stage.sv
// Result register of the scroll and address register unit.
// Depends on saru_pkg.
module saru_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load_i,
  input  saru_pkg::result_t    result_i,
  input  logic                 out_stall,
  output logic                 ready_o,
  output logic                 out_valid,
  output saru_pkg::result_t    result_o
);

  logic              valid_r;
  logic              valid_nxt;
  saru_pkg::result_t result_r;

  // Room when empty or when the held word leaves this edge
  assign ready_o = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load_i) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      result_r <= result_i;
    end
  end

  assign out_valid = valid_r;
  assign result_o  = result_r;

endmodule

### src/scroll_address_register_unit_core.sv
// Scroll and address register unit: takes one event word per clock while in_stall is low and
// returns one result word per event, through the input register and then the result register.
// The address state is updated between the input register and the result register; the unit
// sustains one word per cycle under continuous flow when the output is not stalled.
// Depends on saru_pkg, saru_in_stage, saru_exec and saru_out_stage.
module scroll_address_register_unit_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_kind,
  input  logic [7:0]  in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] out_vram_address,
  output logic [13:0] out_name_fetch_address,
  output logic [13:0] out_attr_fetch_address,
  output logic [2:0]  out_attr_shift,
  output logic [2:0]  out_fine_x_out,
  output logic [2:0]  out_fine_y_out,
  output logic        out_toggle_out
);

  saru_pkg::stage_ctl_t ctl;
  saru_pkg::item_t      item;
  saru_pkg::result_t    result_nxt;
  saru_pkg::result_t    result;
  logic                 in_full;
  logic                 out_ready;

  // A held event moves into the state when the result register has room
  assign ctl.out_ready = out_ready;
  assign ctl.fire      = in_full && out_ready;

  saru_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_kind  (in_kind),
    .in_data  (in_data),
    .ctl_i    (ctl),
    .full_o   (in_full),
    .item_o   (item)
  );

  saru_exec u_exec (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (ctl),
    .item_i   (item),
    .result_o (result_nxt)
  );

  saru_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_i    (ctl.fire),
    .result_i  (result_nxt),
    .out_stall (out_stall),
    .ready_o   (out_ready),
    .out_valid (out_valid),
    .result_o  (result)
  );

  assign out_vram_address       = result.vram_address;
  assign out_name_fetch_address = result.name_fetch_address;
  assign out_attr_fetch_address = result.attr_fetch_address;
  assign out_attr_shift         = result.attr_shift;
  assign out_fine_x_out         = result.fine_x;
  assign out_fine_y_out         = result.fine_y;
  assign out_toggle_out         = result.toggle;

endmodule

### src/saru_checker.sv
// Port-level checker for the scroll and address register unit, with its bind.
// Depends on scroll_address_register_unit_core_assert.svh.
`include "scroll_address_register_unit_core_assert.svh"

module saru_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [14:0] out_vram_address,
  input logic [13:0] out_name_fetch_address,
  input logic [13:0] out_attr_fetch_address,
  input logic [2:0]  out_attr_shift,
  input logic [2:0]  out_fine_y_out
);

  // A stalled result word holds
  `SARU_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_vram_address), "stalled result changed")

  // Nametable fetch tracks the current address
  `SARU_ASSERT(a_name_addr, out_valid |-> out_name_fetch_address == {2'b10, out_vram_address[11:0]}, "nametable fetch address mismatch")

  // Attribute fetch, shift and fine Y all come from the same address
  `SARU_ASSERT(a_attr_addr, out_valid |-> out_attr_fetch_address[11:10] == out_vram_address[11:10] && out_attr_shift == {out_vram_address[6], out_vram_address[1], 1'b0} && out_fine_y_out == out_vram_address[14:12], "attribute or fine Y mismatch")

  // No result word right after reset
  `SARU_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind scroll_address_register_unit_core saru_checker u_saru_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .out_valid              (out_valid),
  .out_stall              (out_stall),
  .out_vram_address       (out_vram_address),
  .out_name_fetch_address (out_name_fetch_address),
  .out_attr_fetch_address (out_attr_fetch_address),
  .out_attr_shift         (out_attr_shift),
  .out_fine_y_out         (out_fine_y_out)
);
